// ----- design/vwbb_pkg.sv -----
// ----------------------------------------------------------------------------
// vwbb_pkg
// Shared widths, reset values and cell control type for the vertex welder.
// ----------------------------------------------------------------------------
package vwbb_pkg;

  localparam int IN_COORD_W  = 12;
  localparam int IN_DATA_W   = 24;
  localparam int IDX_OUT_W   = 7;
  localparam int BOX_OUT_W   = 13;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 2;
  localparam int THR_W       = 25;

  localparam logic [THR_W-1:0] THR_RESET = 25'd500;

  // control type used by every cell of the vertex ring; shift is shared, load is per cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // result flags carried in tuser, highest bit first
  typedef struct packed {
    logic table_full;
    logic is_new;
  } out_flags_t;

endpackage

// ----- design/vertex_weld_with_bounding_box.sv -----
// ----------------------------------------------------------------------------
// vertex_weld_with_bounding_box
// Welds triangle corners onto a table of distinct vertices held in a ring of
// cells, and keeps a running bounding box over closed triangles.
// ----------------------------------------------------------------------------
// a new point is taken only once the previous one has been committed, after
//   one full turn of the vertex ring past the single distance unit
// a finished result may wait in the output register while the next beat is taken
// reset: threshold 500, no vertices, phase 0, box -1; stored points undefined
module vertex_weld_with_bounding_box #(
  parameter int TABLE_DEPTH = 128,
  parameter int COORD_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_x, point_y
  input  logic [vwbb_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vertex_index, box_min_x, box_min_y, box_max_x, box_max_y, zero fill
  output logic [vwbb_pkg::OUT_DATA_W-1:0]   out_tdata,
  // is_new, table_full
  output logic [vwbb_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [vwbb_pkg::THR_W-1:0]        cfg_wdata
);

  localparam int CW   = COORD_BITS;
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int XEXT = (CW > vwbb_pkg::IN_COORD_W) ? CW : vwbb_pkg::IN_COORD_W;
  localparam int BW   = CW + 1;
  localparam int BEXT = (BW > vwbb_pkg::BOX_OUT_W) ? BW : vwbb_pkg::BOX_OUT_W;
  localparam int IEXT = (IW > vwbb_pkg::IDX_OUT_W) ? IW : vwbb_pkg::IDX_OUT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                 state_r;
  logic [IW-1:0]              step_r;
  logic                       drain_r;
  logic                       found_r;
  logic [IW-1:0]              found_idx_r;
  logic [CNTW-1:0]            cnt_r;
  logic [1:0]                 phase_r;
  logic [vwbb_pkg::THR_W-1:0] thr_r;
  logic [CW-1:0]              pt_x_r;
  logic [CW-1:0]              pt_y_r;
  logic [CW-1:0]              tri_r   [4];
  logic [CW-1:0]              tri_nxt [4];
  logic signed [BW-1:0]       box_r   [4];
  logic signed [BW-1:0]       box_nxt [4];
  logic signed [BW-1:0]       tri_s   [4];

  logic                       out_valid_r;
  logic [IW-1:0]              out_idx_r;
  vwbb_pkg::out_flags_t       out_flags_r;
  logic                       out_last_r;
  logic signed [BW-1:0]       out_box_r [4];

  logic [XEXT-1:0]            in_x_ext;
  logic [XEXT-1:0]            in_y_ext;
  logic                       scanning;
  logic                       commit;
  logic                       do_append;
  logic                       feed_valid;
  logic                       hit;
  logic [IW-1:0]              hit_idx;
  logic                       box_none;

  logic [CW-1:0] ring_x [TABLE_DEPTH];
  logic [CW-1:0] ring_y [TABLE_DEPTH];

  assign in_x_ext = XEXT'(in_tdata[vwbb_pkg::IN_COORD_W-1:0]);
  assign in_y_ext = XEXT'(in_tdata[vwbb_pkg::IN_DATA_W-1:vwbb_pkg::IN_COORD_W]);

  assign in_tready  = (state_r == ST_IDLE);
  assign scanning   = (state_r == ST_SCAN);
  assign commit     = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign do_append  = !found_r && (cnt_r < CNTW'(TABLE_DEPTH));
  assign feed_valid = scanning && (CNTW'(step_r) < cnt_r);

  // ring: each cell takes its upper neighbour, so the head sees entry step_r
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    vwbb_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift = scanning;
    assign ctrl.load  = commit && do_append && (cnt_r[IW-1:0] == IW'(j));
    vwbb_cell #(.CW(CW)) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .nbr_x  (ring_x[(j + 1) % TABLE_DEPTH]),
      .nbr_y  (ring_y[(j + 1) % TABLE_DEPTH]),
      .load_x (pt_x_r),
      .load_y (pt_y_r),
      .vx     (ring_x[j]),
      .vy     (ring_y[j])
    );
  end

  vwbb_dist #(.CW(CW), .IW(IW)) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_valid (feed_valid),
    .feed_idx   (step_r),
    .head_x     (ring_x[0]),
    .head_y     (ring_y[0]),
    .pt_x       (pt_x_r),
    .pt_y       (pt_y_r),
    .thr        (thr_r),
    .hit        (hit),
    .hit_idx    (hit_idx)
  );

  // triangle extent and box after this corner
  always_comb begin
    if (phase_r == 2'd0) begin
      tri_nxt[0] = pt_x_r;
      tri_nxt[1] = pt_y_r;
      tri_nxt[2] = pt_x_r;
      tri_nxt[3] = pt_y_r;
    end else begin
      tri_nxt[0] = (pt_x_r < tri_r[0]) ? pt_x_r : tri_r[0];
      tri_nxt[1] = (pt_y_r < tri_r[1]) ? pt_y_r : tri_r[1];
      tri_nxt[2] = (pt_x_r > tri_r[2]) ? pt_x_r : tri_r[2];
      tri_nxt[3] = (pt_y_r > tri_r[3]) ? pt_y_r : tri_r[3];
    end
    for (int k = 0; k < 4; k++) begin
      tri_s[k] = $signed({1'b0, tri_nxt[k]});
    end
    box_none = (box_r[0] == '1);
    for (int k = 0; k < 4; k++) begin
      box_nxt[k] = box_r[k];
    end
    if (phase_r == 2'd2) begin
      if (box_none || tri_s[0] < box_r[0]) box_nxt[0] = tri_s[0];
      if (box_none || tri_s[1] < box_r[1]) box_nxt[1] = tri_s[1];
      if (box_none || tri_s[2] > box_r[2]) box_nxt[2] = tri_s[2];
      if (box_none || tri_s[3] > box_r[3]) box_nxt[3] = tri_s[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      drain_r     <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      phase_r     <= 2'd0;
      thr_r       <= vwbb_pkg::THR_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        box_r[k] <= '1;
      end
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            found_r <= 1'b0;
            step_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            found_r <= 1'b1;
          end
          if (step_r == IW'(TABLE_DEPTH - 1)) begin
            drain_r <= 1'b0;
            state_r <= ST_DRAIN;
          end else begin
            step_r <= step_r + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (hit) begin
            found_r <= 1'b1;
          end
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            if (do_append) begin
              cnt_r <= cnt_r + CNTW'(1);
            end
            for (int k = 0; k < 4; k++) begin
              box_r[k] <= box_nxt[k];
            end
            phase_r <= (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pt_x_r <= in_x_ext[CW-1:0];
      pt_y_r <= in_y_ext[CW-1:0];
    end
    // ascending scan, so the last hit is the highest matching index
    if (hit) begin
      found_idx_r <= hit_idx;
    end
    if (commit) begin
      for (int k = 0; k < 4; k++) begin
        tri_r[k]     <= tri_nxt[k];
        out_box_r[k] <= box_nxt[k];
      end
      out_last_r             <= (phase_r == 2'd2);
      out_flags_r.is_new     <= do_append;
      out_flags_r.table_full <= !found_r && !do_append;
      if (found_r) begin
        out_idx_r <= found_idx_r;
      end else if (do_append) begin
        out_idx_r <= cnt_r[IW-1:0];
      end else begin
        out_idx_r <= '0;
      end
    end
  end

  logic [IEXT-1:0] idx_ext;
  logic [BEXT-1:0] box_ext [4];

  always_comb begin
    idx_ext = IEXT'(out_idx_r);
    for (int k = 0; k < 4; k++) begin
      box_ext[k] = BEXT'(out_box_r[k]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flags_r;
  assign out_tdata  = {5'd0,
                       box_ext[3][vwbb_pkg::BOX_OUT_W-1:0],
                       box_ext[2][vwbb_pkg::BOX_OUT_W-1:0],
                       box_ext[1][vwbb_pkg::BOX_OUT_W-1:0],
                       box_ext[0][vwbb_pkg::BOX_OUT_W-1:0],
                       idx_ext[vwbb_pkg::IDX_OUT_W-1:0]};

endmodule

// ----- design/vwbb_cell.sv -----
// ----------------------------------------------------------------------------
// vwbb_cell
// One slot of the vertex ring: holds a stored point, passes it to its
// neighbour while the ring turns, or takes a new point on append.
// ----------------------------------------------------------------------------
module vwbb_cell #(
  parameter int CW = 12
) (
  input  logic                clk,
  input  vwbb_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       nbr_x,
  input  logic [CW-1:0]       nbr_y,
  input  logic [CW-1:0]       load_x,
  input  logic [CW-1:0]       load_y,
  output logic [CW-1:0]       vx,
  output logic [CW-1:0]       vy
);

  logic [CW-1:0] x_r;
  logic [CW-1:0] y_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end else if (ctrl.load) begin
      x_r <= load_x;
      y_r <= load_y;
    end
  end

  assign vx = x_r;
  assign vy = y_r;

endmodule

// ----- design/vwbb_dist.sv -----
// ----------------------------------------------------------------------------
// vwbb_dist
// Squared distance pipeline at the head of the ring: absolute differences,
// squares, then sum and compare against the merge threshold.
// ----------------------------------------------------------------------------
module vwbb_dist #(
  parameter int CW = 12,
  parameter int IW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       feed_valid,
  input  logic [IW-1:0]              feed_idx,
  input  logic [CW-1:0]              head_x,
  input  logic [CW-1:0]              head_y,
  input  logic [CW-1:0]              pt_x,
  input  logic [CW-1:0]              pt_y,
  input  logic [vwbb_pkg::THR_W-1:0] thr,
  output logic                       hit,
  output logic [IW-1:0]              hit_idx
);

  localparam int SQW  = 2 * CW;
  localparam int SW   = SQW + 1;
  localparam int CMPW = (SW > vwbb_pkg::THR_W) ? SW : vwbb_pkg::THR_W;

  logic           v1_r;
  logic           v2_r;
  logic [IW-1:0]  i1_r;
  logic [IW-1:0]  i2_r;
  logic [CW-1:0]  dx_r;
  logic [CW-1:0]  dy_r;
  logic [SQW-1:0] sqx_r;
  logic [SQW-1:0] sqy_r;
  logic [SW-1:0]  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= feed_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r  <= feed_idx;
    dx_r  <= (head_x > pt_x) ? (head_x - pt_x) : (pt_x - head_x);
    dy_r  <= (head_y > pt_y) ? (head_y - pt_y) : (pt_y - head_y);
    i2_r  <= i1_r;
    sqx_r <= SQW'(dx_r) * SQW'(dx_r);
    sqy_r <= SQW'(dy_r) * SQW'(dy_r);
  end

  assign sum     = SW'(sqx_r) + SW'(sqy_r);
  assign hit     = v2_r && (CMPW'(sum) < CMPW'(thr));
  assign hit_idx = i2_r;

endmodule
